/* hw/rtl/rog_pkg.sv */
// Shared constants and types for the radius of gyration core.
package rog_pkg;

   localparam int ATOM_CAP  = 4096;
   localparam int COORD_W   = 24;
   localparam int RADIUS_W  = 25;
   localparam int ATOMS_W   = 13;

   localparam int ADDR_W  = $clog2(ATOM_CAP);
   localparam int CNT_W   = $clog2(ATOM_CAP + 1);
   localparam int SUM_W   = COORD_W + ADDR_W;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int ACC_W   = SQ_W + $clog2(3 * ATOM_CAP);
   localparam int ROOT_W  = 2 * RADIUS_W;
   localparam int DCNT_W  = $clog2(ACC_W + 1);

   typedef struct packed {
      logic              start;
      logic [ACC_W-1:0]  dividend;
      logic [CNT_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [ACC_W-1:0]  quotient;
   } div_rsp_type;

endpackage

/* hw/rtl/rog_if.sv */
// Valid/ready channel interfaces for atom beats and result beats.
interface rog_req_if;
   logic                         valid;
   logic                         ready;
   logic [rog_pkg::COORD_W-1:0]  x_coord;
   logic [rog_pkg::COORD_W-1:0]  y_coord;
   logic [rog_pkg::COORD_W-1:0]  z_coord;
   logic                         last_atom;

   modport source (output valid, x_coord, y_coord, z_coord, last_atom, input ready);
   modport sink   (input valid, x_coord, y_coord, z_coord, last_atom, output ready);
endinterface

interface rog_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rog_pkg::RADIUS_W-1:0]  radius;
   logic [rog_pkg::ATOMS_W-1:0]   atoms_used;
   logic                          overflowed;

   modport source (output valid, radius, atoms_used, overflowed, input ready);
   modport sink   (input valid, radius, atoms_used, overflowed, output ready);
endinterface

/* hw/rtl/rog_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned.
module rog_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rog_pkg::div_req_type  req,
   output rog_pkg::div_rsp_type  rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rog_pkg::DCNT_W-1:0]    cnt_ff, cnt_in;
   logic [rog_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic [rog_pkg::CNT_W-1:0]     dsr_ff, dsr_in;
   logic [rog_pkg::ACC_W-1:0]     quo_ff, quo_in;
   logic [rog_pkg::CNT_W:0]       trial;
   logic                          fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[rog_pkg::ACC_W-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? rog_pkg::CNT_W'(trial - {1'b0, dsr_ff})
                       : rog_pkg::CNT_W'(trial);
         quo_in = {quo_ff[rog_pkg::ACC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rog_pkg::DCNT_W'(rog_pkg::ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* hw/rtl/radius_of_gyration_core.sv */
// Top level: unweighted radius of gyration over a stored atom set.
//
//  channel  dir  beat contents                             accepted when
//  req_beat in   x_coord, y_coord, z_coord, last_atom      valid && ready
//  rsp_beat out  radius, atoms_used, overflowed            valid && ready
//
// Loading: one atom per cycle; ready stays high while the sequencer is idle,
//   even with a result waiting in the output register.
// After the last atom: three center divides on the shared restoring divider, then
//   per stored atom a memory read, then square and accumulate per axis on one
//   multiplier, one more divide, the square root steps and the output state.
// Reset is synchronous; the coordinate memories need no clearing pass.
// A finished result that finds the output register full waits in the output state.
module radius_of_gyration_core (
   input  logic             clock,
   input  logic             reset,
   rog_req_if.sink          req_beat,
   rog_rsp_if.source        rsp_beat
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CEN  = 4'd1;
   localparam logic [3:0] S_CENW = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_SQ   = 4'd4;
   localparam logic [3:0] S_AC   = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_DIVW = 4'd7;
   localparam logic [3:0] S_ROOT = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   localparam int C = rog_pkg::COORD_W;
   localparam int R = rog_pkg::ROOT_W;

   // coordinate stores
   logic signed [C-1:0] x_mem [rog_pkg::ATOM_CAP];
   logic signed [C-1:0] y_mem [rog_pkg::ATOM_CAP];
   logic signed [C-1:0] z_mem [rog_pkg::ATOM_CAP];
   logic signed [C-1:0] rd_x_ff, rd_y_ff, rd_z_ff;

   logic [3:0]                         state_ff, state_in;
   logic [1:0]                         axis_ff, axis_in;
   logic signed [rog_pkg::SUM_W-1:0]   sum_ff [3];
   logic signed [rog_pkg::SUM_W-1:0]   sum_in [3];
   logic signed [C-1:0]                cen_ff [3];
   logic signed [C-1:0]                cen_in [3];
   logic [rog_pkg::CNT_W-1:0]          count_ff, count_in;
   logic                               drop_ff, drop_in;
   logic [rog_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic [rog_pkg::SQ_W-1:0]           prod_ff, prod_in;
   logic [rog_pkg::ACC_W-1:0]          acc_ff, acc_in;
   logic [R-1:0]                       rt_val_ff, rt_val_in;
   logic [R-1:0]                       rt_res_ff, rt_res_in;
   logic [R-1:0]                       rt_bit_ff, rt_bit_in;
   logic                               sat_ff, sat_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rog_pkg::RADIUS_W-1:0]       rsp_radius_ff, rsp_radius_in;
   logic [rog_pkg::ATOMS_W-1:0]        rsp_atoms_ff, rsp_atoms_in;
   logic                               rsp_ovf_ff, rsp_ovf_in;

   rog_pkg::div_req_type div_req;
   rog_pkg::div_rsp_type div_rsp;

   logic                               accept, room;
   logic signed [C-1:0]                in_c [3];
   logic signed [rog_pkg::SUM_W-1:0]   sum_sel;
   logic [rog_pkg::SUM_W-1:0]          sum_mag;
   logic [C-1:0]                       q_low;
   logic signed [C-1:0]                coord_sel;
   logic signed [rog_pkg::DIFF_W-1:0]  diff;
   logic [rog_pkg::DIFF_W-1:0]         diff_mag;
   logic [rog_pkg::ACC_W+R-1:0]        q_ext;
   logic [R:0]                         rt_trial;

   assign room     = (count_ff < rog_pkg::CNT_W'(rog_pkg::ATOM_CAP));
   assign accept   = req_beat.valid && req_beat.ready;
   assign req_beat.ready = (state_ff == S_IDLE);
   assign in_c[0]  = req_beat.x_coord;
   assign in_c[1]  = req_beat.y_coord;
   assign in_c[2]  = req_beat.z_coord;

   // store writes at load, registered read during the second pass
   always_ff @(posedge clock) begin
      if (accept && room) begin
         x_mem[count_ff[rog_pkg::ADDR_W-1:0]] <= req_beat.x_coord;
         y_mem[count_ff[rog_pkg::ADDR_W-1:0]] <= req_beat.y_coord;
         z_mem[count_ff[rog_pkg::ADDR_W-1:0]] <= req_beat.z_coord;
      end
      rd_x_ff <= x_mem[idx_ff[rog_pkg::ADDR_W-1:0]];
      rd_y_ff <= y_mem[idx_ff[rog_pkg::ADDR_W-1:0]];
      rd_z_ff <= z_mem[idx_ff[rog_pkg::ADDR_W-1:0]];
   end

   rog_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      sum_sel  = sum_ff[axis_ff];
      sum_mag  = sum_sel[rog_pkg::SUM_W-1] ? rog_pkg::SUM_W'(-sum_sel)
                                           : rog_pkg::SUM_W'(sum_sel);
      q_low    = div_rsp.quotient[C-1:0];
      case (axis_ff)
         2'd0:    coord_sel = rd_x_ff;
         2'd1:    coord_sel = rd_y_ff;
         default: coord_sel = rd_z_ff;
      endcase
      diff     = {coord_sel[C-1], coord_sel} - {cen_ff[axis_ff][C-1], cen_ff[axis_ff]};
      diff_mag = diff[rog_pkg::DIFF_W-1] ? rog_pkg::DIFF_W'(-diff)
                                         : rog_pkg::DIFF_W'(diff);
      q_ext    = {R'(0), div_rsp.quotient};
      rt_trial = {1'b0, rt_val_ff} - ({1'b0, rt_res_ff} + {1'b0, rt_bit_ff});

      div_req.start    = 1'b0;
      div_req.dividend = rog_pkg::ACC_W'(sum_mag);
      div_req.divisor  = count_ff;

      state_in      = state_ff;
      axis_in       = axis_ff;
      sum_in        = sum_ff;
      cen_in        = cen_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rt_val_in     = rt_val_ff;
      rt_res_in     = rt_res_ff;
      rt_bit_in     = rt_bit_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_beat.ready;
      rsp_radius_in = rsp_radius_ff;
      rsp_atoms_in  = rsp_atoms_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (room) begin
                  for (int a = 0; a < 3; a++) begin
                     sum_in[a] = sum_ff[a] +
                        {{(rog_pkg::SUM_W-C){in_c[a][C-1]}}, in_c[a]};
                  end
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_beat.last_atom) begin
                  axis_in  = 2'd0;
                  state_in = S_CEN;
               end
            end
         end
         S_CEN: begin
            div_req.start = 1'b1;
            state_in      = S_CENW;
         end
         S_CENW: begin
            if (div_rsp.done) begin
               // truncation toward zero: divide magnitudes, restore sign
               cen_in[axis_ff] = sum_sel[rog_pkg::SUM_W-1] ? C'(-q_low) : q_low;
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  idx_in   = '0;
                  acc_in   = '0;
                  state_in = S_RD;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_CEN;
               end
            end
         end
         S_RD: state_in = S_SQ;
         S_SQ: begin
            prod_in  = diff_mag * diff_mag;
            state_in = S_AC;
         end
         S_AC: begin
            acc_in = acc_ff + rog_pkg::ACC_W'(prod_ff);
            if (axis_ff == 2'd2) begin
               axis_in = 2'd0;
               idx_in  = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == count_ff) ? S_DIV : S_RD;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_SQ;
            end
         end
         S_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = acc_ff;
            state_in         = S_DIVW;
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               sat_in    = |q_ext[rog_pkg::ACC_W+R-1:R];
               rt_val_in = q_ext[R-1:0];
               rt_res_in = '0;
               rt_bit_in = R'(1) << (R - 2);
               state_in  = S_ROOT;
            end
         end
         S_ROOT: begin
            // bit-pair square root, one result bit per step
            if (rt_bit_ff == '0) begin
               state_in = S_OUT;
            end else begin
               if (!rt_trial[R]) begin
                  rt_val_in = rt_trial[R-1:0];
                  rt_res_in = (rt_res_ff >> 1) + rt_bit_ff;
               end else begin
                  rt_res_in = rt_res_ff >> 1;
               end
               rt_bit_in = rt_bit_ff >> 2;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_radius_in = sat_ff ? '1 : rt_res_ff[rog_pkg::RADIUS_W-1:0];
               rsp_atoms_in  = rog_pkg::ATOMS_W'(count_ff);
               rsp_ovf_in    = drop_ff;
               for (int a = 0; a < 3; a++) begin
                  sum_in[a] = '0;
               end
               count_in = '0;
               drop_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
      cen_ff        <= cen_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rt_val_ff     <= rt_val_in;
      rt_res_ff     <= rt_res_in;
      rt_bit_ff     <= rt_bit_in;
      sat_ff        <= sat_in;
      rsp_radius_ff <= rsp_radius_in;
      rsp_atoms_ff  <= rsp_atoms_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_beat.valid      = rsp_valid_ff;
   assign rsp_beat.radius     = rsp_radius_ff;
   assign rsp_beat.atoms_used = rsp_atoms_ff;
   assign rsp_beat.overflowed = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rog_pkg::CNT_W'(rog_pkg::ATOM_CAP))
      else $error("atom count beyond capacity");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (count_ff == rog_pkg::CNT_W'(rog_pkg::ATOM_CAP)))
      else $error("drop flagged before store full");
   a_pass_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_SQ || state_ff == S_AC) |->
      (count_ff != '0 && idx_ff < count_ff))
      else $error("second pass outside stored atoms");
`endif

endmodule
